>>> hw/rtl/shell_line_tokenizer_unit_defines.svh
// ----------------------------------------------------------------------------
// Shell line tokenizer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SHELL_LINE_TOKENIZER_UNIT_DEFINES_SVH
`define SHELL_LINE_TOKENIZER_UNIT_DEFINES_SVH

// condition must never hold
`define SLT_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("slt: forbidden condition");

// antecedent implies consequent in the next cycle
`define SLT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slt: expected follow-up missing");

`endif

>>> hw/rtl/slt_pkg.sv
// ----------------------------------------------------------------------------
// Shell line tokenizer package
// Character codes, result and bundle types, queue sizing.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;

  localparam int RES_MAX = 3;
  localparam int CNT_W   = $clog2(RES_MAX + 1);
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [7:0] chr;
    logic       has_char;
    logic       token_end;
    logic       is_op;
    logic       line_end;
  } slt_res_t;

  typedef struct packed {
    slt_res_t [RES_MAX-1:0] res;
    logic [CNT_W-1:0]       cnt;
  } slt_bundle_t;

  function automatic slt_res_t mk_res(logic [7:0] chr, logic has_char, logic token_end,
                                      logic is_op, logic line_end);
    slt_res_t r;
    r.chr       = chr;
    r.has_char  = has_char;
    r.token_end = token_end;
    r.is_op     = is_op;
    r.line_end  = line_end;
    return r;
  endfunction

endpackage

>>> hw/rtl/slt_front.sv
// ----------------------------------------------------------------------------
// Shell line tokenizer front end
// Accepts one byte per cycle unless the queue is full, tracks lexer state and builds a result bundle.
// ----------------------------------------------------------------------------
module slt_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_char,
  input  logic                 q_full,
  output logic                 q_push,
  output slt_pkg::slt_bundle_t q_data
);
  import slt_pkg::*;
  `include "shell_line_tokenizer_unit_defines.svh"

  typedef enum logic [1:0] {
    M_IDLE  = 2'd0,
    M_WORD  = 2'd1,
    M_QUOTE = 2'd2,
    M_AFTER = 2'd3
  } lex_mode_t;

  lex_mode_t   mode_r, mode_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        held_vld_r, held_vld_nxt;
  logic        word_open_r, word_open_nxt;
  logic [7:0]  spec_r, spec_nxt;
  logic        spec_vld_r, spec_vld_nxt;
  logic        in_acc;
  logic        is_eol;
  slt_bundle_t bnd;
  logic [CNT_W-1:0] n;

  assign in_stall = q_full;
  assign in_acc   = in_valid && !q_full;
  assign is_eol   = (in_char == CH_NUL) || (in_char == CH_LF);

  always_comb begin
    bnd           = '0;
    n             = '0;
    mode_nxt      = mode_r;
    held_nxt      = held_r;
    held_vld_nxt  = held_vld_r;
    word_open_nxt = word_open_r;
    spec_nxt      = spec_r;
    spec_vld_nxt  = spec_vld_r;
    if (spec_vld_r && in_char == spec_r) begin
      spec_vld_nxt = 1'b0;
      spec_nxt     = '0;
      bnd.res[n]   = mk_res(spec_r, 1'b1, 1'b0, 1'b1, 1'b0);
      n            = n + 1'b1;
      bnd.res[n]   = mk_res(in_char, 1'b1, 1'b1, 1'b1, 1'b0);
      n            = n + 1'b1;
    end else begin
      if (spec_vld_r) begin
        spec_vld_nxt = 1'b0;
        spec_nxt     = '0;
        bnd.res[n]   = mk_res(spec_r, 1'b1, 1'b1, 1'b1, 1'b0);
        n            = n + 1'b1;
      end
      if (is_eol || (mode_r != M_QUOTE && (in_char == CH_SPACE ||
          in_char inside {CH_AMP, CH_PIPE, CH_SEMI, CH_GT, CH_LT, CH_LPAR, CH_RPAR}))) begin
        // flush open word
        if (word_open_r) begin
          bnd.res[n] = held_vld_r ? mk_res(held_r, 1'b1, 1'b1, 1'b0, 1'b0)
                                  : mk_res(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
          n = n + 1'b1;
        end
        word_open_nxt = 1'b0;
        held_vld_nxt  = 1'b0;
        held_nxt      = '0;
        mode_nxt      = M_IDLE;
        if (is_eol) begin
          bnd.res[n] = mk_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
          n = n + 1'b1;
        end else if (in_char != CH_SPACE) begin
          spec_nxt     = in_char;
          spec_vld_nxt = 1'b1;
        end
      end else if (in_char == CH_QUOTE) begin
        word_open_nxt = 1'b1;
        mode_nxt      = (mode_r == M_QUOTE) ? M_AFTER : M_QUOTE;
      end else begin
        if (held_vld_r) begin
          bnd.res[n] = mk_res(held_r, 1'b1, 1'b0, 1'b0, 1'b0);
          n = n + 1'b1;
        end
        held_nxt      = in_char;
        held_vld_nxt  = 1'b1;
        word_open_nxt = 1'b1;
        if (mode_r != M_QUOTE) begin
          mode_nxt = M_WORD;
        end
      end
    end
    bnd.cnt = n;
  end

  assign q_push = in_acc && (bnd.cnt != '0);
  assign q_data = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_IDLE;
      held_r      <= '0;
      held_vld_r  <= 1'b0;
      word_open_r <= 1'b0;
      spec_r      <= '0;
      spec_vld_r  <= 1'b0;
    end else if (in_acc) begin
      mode_r      <= mode_nxt;
      held_r      <= held_nxt;
      held_vld_r  <= held_vld_nxt;
      word_open_r <= word_open_nxt;
      spec_r      <= spec_nxt;
      spec_vld_r  <= spec_vld_nxt;
    end
  end

  `SLT_ASSERT_NEVER(a_held_needs_word, held_vld_r && !word_open_r)
  `SLT_ASSERT_NEXT(a_eol_idle, in_acc && is_eol,
                   mode_r == M_IDLE && !word_open_r && !held_vld_r && !spec_vld_r)

endmodule

>>> hw/rtl/slt_queue.sv
// ----------------------------------------------------------------------------
// Shell line tokenizer bundle queue
// Short FIFO of result bundles between front end and back end.
// ----------------------------------------------------------------------------
module slt_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  slt_pkg::slt_bundle_t push_data,
  output logic                 full,
  input  logic                 pop,
  output slt_pkg::slt_bundle_t head,
  output logic                 empty
);
  import slt_pkg::*;
  `include "shell_line_tokenizer_unit_defines.svh"

  slt_bundle_t        mem_r [Q_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (cnt_r == QCNT_W'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `SLT_ASSERT_NEVER(a_no_overflow, push && full)
  `SLT_ASSERT_NEVER(a_no_underflow, pop && empty)

endmodule

>>> hw/rtl/slt_back.sv
// ----------------------------------------------------------------------------
// Shell line tokenizer back end
// Unpacks bundles into single result transactions through an output register.
// ----------------------------------------------------------------------------
module slt_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  slt_pkg::slt_bundle_t q_head,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output slt_pkg::slt_res_t    out_res
);
  import slt_pkg::*;
  `include "shell_line_tokenizer_unit_defines.svh"

  slt_res_t [RES_MAX-1:0] cur_r;
  logic [CNT_W-1:0]       rem_r;
  logic                   out_valid_r;
  slt_res_t               out_res_r;
  logic                   adv;

  assign adv       = !out_valid_r || !out_stall;
  assign q_pop     = adv && (rem_r == '0) && !q_empty;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rem_r       <= '0;
    end else if (adv) begin
      if (rem_r != '0) begin
        out_valid_r <= 1'b1;
        rem_r       <= rem_r - 1'b1;
      end else if (!q_empty) begin
        out_valid_r <= 1'b1;
        rem_r       <= q_head.cnt - 1'b1;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (rem_r != '0) begin
        out_res_r <= cur_r[0];
        cur_r     <= cur_r >> $bits(slt_res_t);
      end else if (!q_empty) begin
        out_res_r <= q_head.res[0];
        cur_r     <= q_head.res >> $bits(slt_res_t);
      end
    end
  end

  `SLT_ASSERT_NEVER(a_pop_when_drained, q_pop && rem_r != '0)
  `SLT_ASSERT_NEXT(a_hold_on_stall, out_valid_r && out_stall,
                   out_valid_r && $stable(rem_r))

endmodule

>>> hw/rtl/shell_line_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// Shell line tokenizer unit
// Splits a command line, one byte per transaction, into token byte results.
// ----------------------------------------------------------------------------
// Accepts one input byte every cycle unless the input stalls. Each byte yields
// zero to three result transactions; these leave one per cycle from an output
// register while out_stall is low, so a byte that yields two or three results
// holds the result side until all of them have left. A two-entry bundle queue
// between the classifying front end and the unpacking back end absorbs those
// bursts and output stalls; the input stalls only while the queue is full.
module shell_line_tokenizer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_has_char,
  output logic       out_token_end,
  output logic       out_is_operator,
  output logic       out_line_end
);
  import slt_pkg::*;

  slt_bundle_t push_data;
  slt_bundle_t head;
  logic        push, pop, full, empty;
  slt_res_t    res;

  slt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_char  (in_char),
    .q_full   (full),
    .q_push   (push),
    .q_data   (push_data)
  );

  slt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  slt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (head),
    .q_empty   (empty),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_char        = res.chr;
  assign out_has_char    = res.has_char;
  assign out_token_end   = res.token_end;
  assign out_is_operator = res.is_op;
  assign out_line_end    = res.line_end;

endmodule
